/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the moisture band alarm.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/mpba_pkg.sv */
// Package of the moisture band alarm: widths, condition codes, register
// indexes and the controller/datapath command and status types. No dependencies.
package mpba_pkg;

  localparam int SAMPLE_BITS = 12;
  // Signed difference of two readings
  localparam int DIFF_W = SAMPLE_BITS + 1;
  // Difference times 100, signed
  localparam int PROD_W = DIFF_W + 7;
  // Magnitude of the dividend, also the quotient width
  localparam int QUO_W = PROD_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int TIME_W = 32;
  localparam int PCT_W = 7;
  localparam int COND_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DRY_READING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WET_READING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DRY_DELAY = 2'd2;

  localparam logic [COND_W-1:0] COND_IDLE = 3'd0;
  localparam logic [COND_W-1:0] COND_VERY_DRY = 3'd1;
  localparam logic [COND_W-1:0] COND_DRY = 3'd2;
  localparam logic [COND_W-1:0] COND_MOIST = 3'd3;
  localparam logic [COND_W-1:0] COND_WET = 3'd4;
  localparam logic [COND_W-1:0] COND_SUBMERGED = 3'd5;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_VERY_DRY_BELOW = 7'd10;
  localparam logic [PCT_W-1:0] PCT_DRY_BELOW = 7'd30;
  localparam logic [PCT_W-1:0] PCT_IDLE_MAX = 7'd40;
  localparam logic [PCT_W-1:0] PCT_MOIST_MAX = 7'd60;
  localparam logic [PCT_W-1:0] PCT_WET_MAX = 7'd90;

  localparam logic [SAMPLE_BITS-1:0] DRY_READING_RESET = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] WET_READING_RESET = '0;
  localparam logic [TIME_W-1:0] DRY_DELAY_RESET = 32'd60000;

  typedef struct packed {
    logic capture;  // latch the accepted sample
    logic load;     // set up the divider operands
    logic step;     // one quotient bit
    logic finish;   // scale, classify, time and write the result
  } mpba_cmd_t;

  typedef struct packed {
    logic div_last;  // the current step produces the last quotient bit
  } mpba_status_t;

endpackage

/* rtl/core/mpba_channels.sv */
// Handshake channels of the moisture band alarm: sample in, result out.
// Depends on mpba_pkg.
interface mpba_sample_if import mpba_pkg::*; ();
  logic valid;
  logic ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_W-1:0] now_ms;

  modport source(output valid, sample, now_ms, input ready);
  modport sink(input valid, sample, now_ms, output ready);
endinterface

interface mpba_result_if import mpba_pkg::*; ();
  logic valid;
  logic ready;
  logic [PCT_W-1:0] moisture_percent;
  logic [COND_W-1:0] condition;
  logic alarm;
  logic span_error;

  modport source(output valid, moisture_percent, condition, alarm, span_error, input ready);
  modport sink(input valid, moisture_percent, condition, alarm, span_error, output ready);
endinterface

/* rtl/core/mpba_ctrl.sv */
// Controller of the moisture band alarm: sequences capture, setup, division
// and finish, and owns the handshakes. Depends on mpba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpba_ctrl import mpba_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  mpba_status_t status,
  output mpba_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV = 2'd2;
  localparam logic [1:0] S_FIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Set valid on a new result, drop it once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_accept_loads, clk, rst, in_valid && in_ready, state == S_LOAD, "accept did not start setup")
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.finish, !out_valid || out_ready, "result overwritten")
  `ASSERT_NEXT(a_div_ends, clk, rst, cmd.step && status.div_last, state == S_FIN, "division did not end")
  `ASSERT_NEXT(a_finish_valid, clk, rst, cmd.finish, out_valid, "finished result not presented")

endmodule

/* rtl/core/mpba_dp.sv */
// Datapath of the moisture band alarm: configuration registers, operand setup,
// bit-serial restoring divider, scaling, classing and dry timer. Depends on mpba_pkg.
module mpba_dp import mpba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [TIME_W-1:0]      now_ms,
  input  mpba_cmd_t              cmd,
  output mpba_status_t           status,
  output logic [PCT_W-1:0]       moisture_percent,
  output logic [COND_W-1:0]      condition,
  output logic                   alarm,
  output logic                   span_error
);

  logic [SAMPLE_BITS-1:0] dry_reading;
  logic [SAMPLE_BITS-1:0] wet_reading;
  logic [TIME_W-1:0]      dry_delay_ms;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [TIME_W-1:0]      now_q;

  logic [SAMPLE_BITS-1:0] rem;
  logic [QUO_W-1:0]       quo;
  logic [SAMPLE_BITS-1:0] den;
  logic                   neg;
  logic                   span_zero;
  logic [CNT_W-1:0]       cnt;

  logic                   dry_timer_running;
  logic [TIME_W-1:0]      dry_start_time;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_reading <= DRY_READING_RESET;
      wet_reading <= WET_READING_RESET;
      dry_delay_ms <= DRY_DELAY_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_DRY_READING: dry_reading <= cfg_data[SAMPLE_BITS-1:0];
        REG_WET_READING: wet_reading <= cfg_data[SAMPLE_BITS-1:0];
        REG_DRY_DELAY:   dry_delay_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= sample;
      now_q <= now_ms;
    end
  end

  // Operand setup: offset times 100 over span, as magnitudes and a sign
  logic signed [DIFF_W-1:0] offs;
  logic signed [DIFF_W-1:0] span;
  logic signed [PROD_W-1:0] prod;
  logic [QUO_W-1:0]         prod_mag;
  logic [SAMPLE_BITS-1:0]   span_mag;

  always_comb begin
    offs = $signed({1'b0, sample_q}) - $signed({1'b0, wet_reading});
    span = $signed({1'b0, dry_reading}) - $signed({1'b0, wet_reading});
    prod = PROD_W'(offs) * PROD_W'(100);
    prod_mag = prod[PROD_W-1] ? QUO_W'(-prod) : QUO_W'(prod);
    span_mag = span[DIFF_W-1] ? SAMPLE_BITS'(-span) : SAMPLE_BITS'(span);
  end

  // Restoring division, one quotient bit per step
  logic [SAMPLE_BITS:0] trial;
  logic                 fits;

  always_comb begin
    trial = {rem, quo[QUO_W-1]};
    fits = (trial >= {1'b0, den});
  end

  assign status.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= '0;
      quo <= prod_mag;
      den <= span_mag;
      neg <= offs[DIFF_W-1] ^ span[DIFF_W-1];
      span_zero <= (span == '0);
      cnt <= CNT_W'(QUO_W - 1);
    end else if (cmd.step) begin
      rem <= fits ? SAMPLE_BITS'(trial - {1'b0, den}) : trial[SAMPLE_BITS-1:0];
      quo <= {quo[QUO_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  // Scale, clamp and classify: a negative quotient clamps to full scale unless the span is zero
  logic [PCT_W-1:0]  pct;
  logic [COND_W-1:0] cond;
  logic              dry_now;
  logic              alarm_now;
  logic [TIME_W-1:0] start_eff;
  logic [TIME_W-1:0] elapsed;

  always_comb begin
    if (span_zero) begin
      pct = '0;
    end else if (neg) begin
      pct = PCT_FULL;
    end else if (quo >= QUO_W'(PCT_FULL)) begin
      pct = '0;
    end else begin
      pct = PCT_FULL - quo[PCT_W-1:0];
    end

    start_eff = dry_timer_running ? dry_start_time : now_q;
    elapsed = now_q - start_eff;
    dry_now = 1'b0;
    alarm_now = 1'b0;
    if (pct >= PCT_DRY_BELOW && pct <= PCT_IDLE_MAX) begin
      cond = COND_IDLE;
    end else if (pct < PCT_DRY_BELOW) begin
      cond = (pct < PCT_VERY_DRY_BELOW) ? COND_VERY_DRY : COND_DRY;
      dry_now = 1'b1;
      alarm_now = (elapsed >= dry_delay_ms);
    end else if (pct <= PCT_MOIST_MAX) begin
      cond = COND_MOIST;
    end else if (pct <= PCT_WET_MAX) begin
      cond = COND_WET;
    end else begin
      cond = COND_SUBMERGED;
      alarm_now = 1'b1;
    end
  end

  // Advance the dry timer: start on the first dry sample, stop on any other
  always_ff @(posedge clk) begin
    if (rst) begin
      dry_timer_running <= 1'b0;
      dry_start_time <= '0;
    end else if (cmd.finish) begin
      dry_timer_running <= dry_now;
      if (dry_now && !dry_timer_running) dry_start_time <= now_q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      moisture_percent <= pct;
      condition <= cond;
      alarm <= alarm_now;
      span_error <= span_zero;
    end
  end

endmodule

/* rtl/core/moisture_percent_band_alarm.sv */
// Top level of the moisture band alarm: controller, datapath and channels.
// Depends on mpba_pkg, mpba_channels, mpba_ctrl and mpba_dp.
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   sample, now_ms
//   results   out  valid/ready   moisture_percent, condition, alarm, span_error
//   cfg       in   cfg_wen       cfg_index, cfg_data
//
// A sample passes through capture, operand setup, one cycle per quotient bit of
// the bit-serial divider, and a finish cycle.
// Reset is synchronous and active high; it restores the configuration defaults
// and stops the dry timer. A new sample is accepted while a result still waits;
// the finish cycle holds while the output register is full and not taken.
module moisture_percent_band_alarm import mpba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mpba_sample_if.sink            samples,
  mpba_result_if.source          results
);

  mpba_cmd_t    cmd;
  mpba_status_t status;

  mpba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mpba_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_wen          (cfg_wen),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample           (samples.sample),
    .now_ms           (samples.now_ms),
    .cmd              (cmd),
    .status           (status),
    .moisture_percent (results.moisture_percent),
    .condition        (results.condition),
    .alarm            (results.alarm),
    .span_error       (results.span_error)
  );

endmodule
